### rtl/scrg_pkg.sv
// Shared types, constants and the tap microcode ROM of the stencil CSR row generator.
// Used by the channel interfaces and by the top level; depends on nothing.

package scrg_pkg;

   localparam int COORD_W = 10;
   localparam int EXT_W   = 11;
   localparam int COL_W   = 30;
   localparam int COEF_W  = 6;
   localparam int POS_W   = 35;
   localparam int MODE_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int UADDR_W = 6;

   // stencil modes
   localparam logic [MODE_W-1:0] MODE_1D3  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_2D5  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_2D9  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_3D7  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_3D27 = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH  = 2'd3;

   // tap offsets
   localparam logic signed [1:0] OFS_N = -2'sd1;
   localparam logic signed [1:0] OFS_Z = 2'sd0;
   localparam logic signed [1:0] OFS_P = 2'sd1;

   // coefficients
   localparam logic signed [COEF_W-1:0] C_M1  = -6'sd1;
   localparam logic signed [COEF_W-1:0] C_M2  = -6'sd2;
   localparam logic signed [COEF_W-1:0] C_M4  = -6'sd4;
   localparam logic signed [COEF_W-1:0] C_2   = 6'sd2;
   localparam logic signed [COEF_W-1:0] C_4   = 6'sd4;
   localparam logic signed [COEF_W-1:0] C_6   = 6'sd6;
   localparam logic signed [COEF_W-1:0] C_8   = 6'sd8;
   localparam logic signed [COEF_W-1:0] C_26  = 6'sd26;

   // program entry points
   localparam logic [UADDR_W-1:0] ENTRY_1D3  = 6'd0;
   localparam logic [UADDR_W-1:0] ENTRY_2D5  = 6'd3;
   localparam logic [UADDR_W-1:0] ENTRY_2D9  = 6'd8;
   localparam logic [UADDR_W-1:0] ENTRY_3D7  = 6'd17;
   localparam logic [UADDR_W-1:0] ENTRY_3D27 = 6'd24;

   // one control word per tap step
   typedef struct packed {
      logic signed [1:0]        dx;
      logic signed [1:0]        dy;
      logic signed [1:0]        dz;
      logic signed [COEF_W-1:0] coef;
      logic                     end_prog;
   } ucode_type;

   function automatic ucode_type uw(input logic signed [1:0] dx,
                                    input logic signed [1:0] dy,
                                    input logic signed [1:0] dz,
                                    input logic signed [COEF_W-1:0] coef,
                                    input logic end_prog);
      ucode_type w;
      w.dx       = dx;
      w.dy       = dy;
      w.dz       = dz;
      w.coef     = coef;
      w.end_prog = end_prog;
      return w;
   endfunction

   function automatic logic [UADDR_W-1:0] mode_entry(input logic [MODE_W-1:0] mode);
      logic [UADDR_W-1:0] a;
      case (mode)
         MODE_1D3:  a = ENTRY_1D3;
         MODE_2D5:  a = ENTRY_2D5;
         MODE_2D9:  a = ENTRY_2D9;
         MODE_3D7:  a = ENTRY_3D7;
         default:   a = ENTRY_3D27;
      endcase
      return a;
   endfunction

   function automatic ucode_type ucode_rom(input logic [UADDR_W-1:0] addr);
      ucode_type w;
      case (addr)
         // 1D 3-point
         6'd0:  w = uw(OFS_N, OFS_Z, OFS_Z, C_M1, 1'b0);
         6'd1:  w = uw(OFS_Z, OFS_Z, OFS_Z, C_2,  1'b0);
         6'd2:  w = uw(OFS_P, OFS_Z, OFS_Z, C_M1, 1'b1);
         // 2D 5-point
         6'd3:  w = uw(OFS_Z, OFS_Z, OFS_Z, C_4,  1'b0);
         6'd4:  w = uw(OFS_N, OFS_Z, OFS_Z, C_M1, 1'b0);
         6'd5:  w = uw(OFS_P, OFS_Z, OFS_Z, C_M1, 1'b0);
         6'd6:  w = uw(OFS_Z, OFS_N, OFS_Z, C_M1, 1'b0);
         6'd7:  w = uw(OFS_Z, OFS_P, OFS_Z, C_M1, 1'b1);
         // 2D 9-point
         6'd8:  w = uw(OFS_Z, OFS_Z, OFS_Z, C_8,  1'b0);
         6'd9:  w = uw(OFS_N, OFS_Z, OFS_Z, C_M2, 1'b0);
         6'd10: w = uw(OFS_P, OFS_Z, OFS_Z, C_M2, 1'b0);
         6'd11: w = uw(OFS_Z, OFS_N, OFS_Z, C_M2, 1'b0);
         6'd12: w = uw(OFS_Z, OFS_P, OFS_Z, C_M2, 1'b0);
         6'd13: w = uw(OFS_N, OFS_N, OFS_Z, C_M1, 1'b0);
         6'd14: w = uw(OFS_N, OFS_P, OFS_Z, C_M1, 1'b0);
         6'd15: w = uw(OFS_P, OFS_N, OFS_Z, C_M1, 1'b0);
         6'd16: w = uw(OFS_P, OFS_P, OFS_Z, C_M1, 1'b1);
         // 3D 7-point
         6'd17: w = uw(OFS_Z, OFS_Z, OFS_Z, C_6,  1'b0);
         6'd18: w = uw(OFS_N, OFS_Z, OFS_Z, C_M1, 1'b0);
         6'd19: w = uw(OFS_P, OFS_Z, OFS_Z, C_M1, 1'b0);
         6'd20: w = uw(OFS_Z, OFS_N, OFS_Z, C_M1, 1'b0);
         6'd21: w = uw(OFS_Z, OFS_P, OFS_Z, C_M1, 1'b0);
         6'd22: w = uw(OFS_Z, OFS_Z, OFS_N, C_M1, 1'b0);
         6'd23: w = uw(OFS_Z, OFS_Z, OFS_P, C_M1, 1'b1);
         // 3D 27-point, dz outer, dy middle, dx inner
         6'd24: w = uw(OFS_N, OFS_N, OFS_N, C_M1, 1'b0);
         6'd25: w = uw(OFS_Z, OFS_N, OFS_N, C_M1, 1'b0);
         6'd26: w = uw(OFS_P, OFS_N, OFS_N, C_M1, 1'b0);
         6'd27: w = uw(OFS_N, OFS_Z, OFS_N, C_M1, 1'b0);
         6'd28: w = uw(OFS_Z, OFS_Z, OFS_N, C_M4, 1'b0);
         6'd29: w = uw(OFS_P, OFS_Z, OFS_N, C_M1, 1'b0);
         6'd30: w = uw(OFS_N, OFS_P, OFS_N, C_M1, 1'b0);
         6'd31: w = uw(OFS_Z, OFS_P, OFS_N, C_M1, 1'b0);
         6'd32: w = uw(OFS_P, OFS_P, OFS_N, C_M1, 1'b0);
         6'd33: w = uw(OFS_N, OFS_N, OFS_Z, C_M1, 1'b0);
         6'd34: w = uw(OFS_Z, OFS_N, OFS_Z, C_M4, 1'b0);
         6'd35: w = uw(OFS_P, OFS_N, OFS_Z, C_M1, 1'b0);
         6'd36: w = uw(OFS_N, OFS_Z, OFS_Z, C_M4, 1'b0);
         6'd37: w = uw(OFS_Z, OFS_Z, OFS_Z, C_26, 1'b0);
         6'd38: w = uw(OFS_P, OFS_Z, OFS_Z, C_M4, 1'b0);
         6'd39: w = uw(OFS_N, OFS_P, OFS_Z, C_M1, 1'b0);
         6'd40: w = uw(OFS_Z, OFS_P, OFS_Z, C_M4, 1'b0);
         6'd41: w = uw(OFS_P, OFS_P, OFS_Z, C_M1, 1'b0);
         6'd42: w = uw(OFS_N, OFS_N, OFS_P, C_M1, 1'b0);
         6'd43: w = uw(OFS_Z, OFS_N, OFS_P, C_M1, 1'b0);
         6'd44: w = uw(OFS_P, OFS_N, OFS_P, C_M1, 1'b0);
         6'd45: w = uw(OFS_N, OFS_Z, OFS_P, C_M1, 1'b0);
         6'd46: w = uw(OFS_Z, OFS_Z, OFS_P, C_M4, 1'b0);
         6'd47: w = uw(OFS_P, OFS_Z, OFS_P, C_M1, 1'b0);
         6'd48: w = uw(OFS_N, OFS_P, OFS_P, C_M1, 1'b0);
         6'd49: w = uw(OFS_Z, OFS_P, OFS_P, C_M1, 1'b0);
         6'd50: w = uw(OFS_P, OFS_P, OFS_P, C_M1, 1'b1);
         default: w = uw(OFS_Z, OFS_Z, OFS_Z, C_M1, 1'b1);
      endcase
      return w;
   endfunction

endpackage

### rtl/scrg_ifs.sv
// Valid/ready channel interfaces of the stencil CSR row generator.
// Depends on scrg_pkg for the field widths.

interface scrg_req_if;
   logic                           valid;
   logic                           ready;
   logic                           restart;
   logic [scrg_pkg::COORD_W-1:0]   point_x;
   logic [scrg_pkg::COORD_W-1:0]   point_y;
   logic [scrg_pkg::COORD_W-1:0]   point_z;

   modport source (output valid, restart, point_x, point_y, point_z, input ready);
   modport sink   (input valid, restart, point_x, point_y, point_z, output ready);
endinterface

interface scrg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [scrg_pkg::COL_W-1:0]           column;
   logic signed [scrg_pkg::COEF_W-1:0]   coefficient;
   logic [scrg_pkg::POS_W-1:0]           entry_position;
   logic                                 last;
   logic                                 out_of_grid;

   modport source (output valid, column, coefficient, entry_position, last, out_of_grid,
                   input ready);
   modport sink   (input valid, column, coefficient, entry_position, last, out_of_grid,
                   output ready);
endinterface

### rtl/stencil_csr_row_generator.sv
// Stencil CSR row generator: one grid point in, that point's CSR row of nonzeros out.
// Depends on scrg_pkg and the channel interfaces in scrg_ifs.sv.
//
// Each accepted point yields its in-grid stencil neighbors in stencil order, one
// word per cycle at best, with linear column, coefficient, running CSR position and
// a last mark; a point outside the grid (or an undefined mode) yields one flagged
// word. No new point is taken until the previous row is sent. A point in the grid
// (3, 5, 9, 7 or 27 taps by mode) goes through setup states that build W*H, y*W,
// z*W*H and the center column, then the microcode ROM is stepped one tap per cycle
// unless the output stalls, and a flush state sends the held entry with its last
// mark; an out-of-grid point goes through ST_OOG. A stalled result channel holds
// the sequencer at the tap that needs the output register. Extents above MAX_EXTENT
// are saturated to it; the running position wraps at 2^35 and restart clears it.

module stencil_csr_row_generator #(
   parameter int MAX_EXTENT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [scrg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scrg_pkg::EXT_W-1:0]        csr_wdata,
   scrg_req_if.sink                          req_port,
   scrg_rsp_if.source                        rsp_port
);

   localparam int EXT_W   = scrg_pkg::EXT_W;
   localparam int COL_W   = scrg_pkg::COL_W;
   localparam int COEF_W  = scrg_pkg::COEF_W;
   localparam int POS_W   = scrg_pkg::POS_W;
   localparam int MODE_W  = scrg_pkg::MODE_W;
   localparam int CRD_W   = scrg_pkg::COORD_W;
   localparam int UADDR_W = scrg_pkg::UADDR_W;
   localparam int WH_W    = 2 * EXT_W;
   localparam int EXT_CAP = (MAX_EXTENT > (2 ** EXT_W) - 1) ? (2 ** EXT_W) - 1 : MAX_EXTENT;

   typedef enum logic [2:0] {
      ST_IDLE, ST_OOG, ST_MUL_WH, ST_MUL_YW, ST_MUL_ZWH, ST_SUM, ST_TAPS, ST_FLUSH
   } state_type;

   // config
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [EXT_W-1:0]  width_ff, width_in, height_ff, height_in, depth_ff, depth_in;

   // per-row context
   state_type          state_ff, state_in;
   logic [UADDR_W-1:0] step_ff, step_in;
   logic [CRD_W-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [EXT_W-1:0]   ew_ff, ew_in, eh_ff, eh_in, ed_ff, ed_in;
   logic [WH_W-1:0]    wh_ff, wh_in;
   logic [COL_W-1:0]   yw_ff, yw_in, zwh_ff, zwh_in, center_ff, center_in;
   logic [POS_W-1:0]   count_ff, count_in;

   // held entry, waiting to learn whether it is the row's last
   logic                     pend_valid_ff, pend_valid_in;
   logic [COL_W-1:0]         pend_col_ff, pend_col_in;
   logic signed [COEF_W-1:0] pend_coef_ff, pend_coef_in;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic [COL_W-1:0]         out_col_ff, out_col_in;
   logic signed [COEF_W-1:0] out_coef_ff, out_coef_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_oog_ff, out_oog_in;

   logic [EXT_W-1:0]   w_cl, h_cl, d_cl, a_ew, a_eh, a_ed;
   logic [CRD_W-1:0]   a_py, a_pz;
   logic               a_oog;
   logic               out_free, out_load, load_oog;
   scrg_pkg::ucode_type uword;
   logic               x_ok, y_ok, z_ok, tap_ok;
   logic [COL_W-1:0]   xoff, yoff, zoff, tap_col;
   logic [2*COL_W-1:0] zprod;

   function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
      return (v > EXT_W'(EXT_CAP)) ? EXT_W'(EXT_CAP) : v;
   endfunction

   assign w_cl = clamp_ext(width_ff);
   assign h_cl = clamp_ext(height_ff);
   assign d_cl = clamp_ext(depth_ff);

   // effective extents and coordinates of an arriving point
   always_comb begin
      a_ew = w_cl;
      a_eh = (mode_ff == scrg_pkg::MODE_1D3) ? EXT_W'(1) : h_cl;
      a_py = (mode_ff == scrg_pkg::MODE_1D3) ? '0 : req_port.point_y;
      a_ed = (mode_ff <= scrg_pkg::MODE_2D9) ? EXT_W'(1) : d_cl;
      a_pz = (mode_ff <= scrg_pkg::MODE_2D9) ? '0 : req_port.point_z;
      a_oog = (mode_ff > scrg_pkg::MODE_3D27)
           || ({1'b0, req_port.point_x} >= a_ew)
           || ({1'b0, a_py} >= a_eh)
           || ({1'b0, a_pz} >= a_ed);
   end

   // tap datapath
   assign uword = scrg_pkg::ucode_rom(step_ff);

   always_comb begin
      x_ok = (uword.dx == scrg_pkg::OFS_Z)
          || ((uword.dx == scrg_pkg::OFS_N) && (px_ff != '0))
          || ((uword.dx == scrg_pkg::OFS_P) && ((EXT_W'(px_ff) + EXT_W'(1)) < ew_ff));
      y_ok = (uword.dy == scrg_pkg::OFS_Z)
          || ((uword.dy == scrg_pkg::OFS_N) && (py_ff != '0))
          || ((uword.dy == scrg_pkg::OFS_P) && ((EXT_W'(py_ff) + EXT_W'(1)) < eh_ff));
      z_ok = (uword.dz == scrg_pkg::OFS_Z)
          || ((uword.dz == scrg_pkg::OFS_N) && (pz_ff != '0))
          || ((uword.dz == scrg_pkg::OFS_P) && ((EXT_W'(pz_ff) + EXT_W'(1)) < ed_ff));
      tap_ok = x_ok && y_ok && z_ok;

      case (uword.dx)
         scrg_pkg::OFS_P: xoff = COL_W'(1);
         scrg_pkg::OFS_N: xoff = '1;
         default:         xoff = '0;
      endcase
      case (uword.dy)
         scrg_pkg::OFS_P: yoff = COL_W'(ew_ff);
         scrg_pkg::OFS_N: yoff = COL_W'(0) - COL_W'(ew_ff);
         default:         yoff = '0;
      endcase
      case (uword.dz)
         scrg_pkg::OFS_P: zoff = COL_W'(wh_ff);
         scrg_pkg::OFS_N: zoff = COL_W'(0) - COL_W'(wh_ff);
         default:         zoff = '0;
      endcase
      // all column math is modulo 2^30
      tap_col = center_ff + xoff + yoff + zoff;
   end

   assign zprod    = COL_W'(pz_ff) * COL_W'(wh_ff);
   assign out_free = !out_valid_ff || rsp_port.ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      mode_in       = mode_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      depth_in      = depth_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      ew_in         = ew_ff;
      eh_in         = eh_ff;
      ed_in         = ed_ff;
      wh_in         = wh_ff;
      yw_in         = yw_ff;
      zwh_in        = zwh_ff;
      center_in     = center_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_col_in   = pend_col_ff;
      pend_coef_in  = pend_coef_ff;
      out_valid_in  = out_valid_ff && !rsp_port.ready;
      out_col_in    = out_col_ff;
      out_coef_in   = out_coef_ff;
      out_pos_in    = out_pos_ff;
      out_last_in   = out_last_ff;
      out_oog_in    = out_oog_ff;
      out_load      = 1'b0;
      load_oog      = 1'b0;

      if (csr_write_en) begin
         case (csr_index)
            scrg_pkg::CSR_MODE:   mode_in   = csr_wdata[MODE_W-1:0];
            scrg_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            scrg_pkg::CSR_HEIGHT: height_in = csr_wdata;
            scrg_pkg::CSR_DEPTH:  depth_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               px_in = req_port.point_x;
               py_in = a_py;
               pz_in = a_pz;
               ew_in = a_ew;
               eh_in = a_eh;
               ed_in = a_ed;
               if (req_port.restart) begin
                  count_in = '0;
               end
               state_in = a_oog ? ST_OOG : ST_MUL_WH;
            end
         end
         ST_OOG: begin
            if (out_free) begin
               out_load    = 1'b1;
               load_oog    = 1'b1;
               out_col_in  = '0;
               out_coef_in = '0;
               out_last_in = 1'b1;
               out_oog_in  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_MUL_WH: begin
            wh_in    = WH_W'(ew_ff) * WH_W'(eh_ff);
            state_in = ST_MUL_YW;
         end
         ST_MUL_YW: begin
            yw_in    = COL_W'(py_ff) * COL_W'(ew_ff);
            state_in = ST_MUL_ZWH;
         end
         ST_MUL_ZWH: begin
            zwh_in   = zprod[COL_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            center_in     = COL_W'(px_ff) + yw_ff + zwh_ff;
            step_in       = scrg_pkg::mode_entry(mode_ff);
            pend_valid_in = 1'b0;
            state_in      = ST_TAPS;
         end
         ST_TAPS: begin
            // an in-grid tap pushes the held entry out, so it needs the output free
            if (!tap_ok || !pend_valid_ff || out_free) begin
               if (tap_ok) begin
                  pend_valid_in = 1'b1;
                  pend_col_in   = tap_col;
                  pend_coef_in  = uword.coef;
                  if (pend_valid_ff) begin
                     out_load    = 1'b1;
                     out_col_in  = pend_col_ff;
                     out_coef_in = pend_coef_ff;
                     out_last_in = 1'b0;
                     out_oog_in  = 1'b0;
                  end
               end
               if (uword.end_prog) begin
                  state_in = ST_FLUSH;
               end else begin
                  step_in = step_ff + UADDR_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_col_in    = pend_col_ff;
               out_coef_in   = pend_coef_ff;
               out_last_in   = 1'b1;
               out_oog_in    = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
         out_pos_in   = count_ff;
         if (!load_oog) begin
            count_in = count_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= scrg_pkg::MODE_1D3;
         width_ff      <= EXT_W'(10);
         height_ff     <= EXT_W'(10);
         depth_ff      <= EXT_W'(10);
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         depth_ff      <= depth_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      step_ff      <= step_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      ew_ff        <= ew_in;
      eh_ff        <= eh_in;
      ed_ff        <= ed_in;
      wh_ff        <= wh_in;
      yw_ff        <= yw_in;
      zwh_ff       <= zwh_in;
      center_ff    <= center_in;
      pend_col_ff  <= pend_col_in;
      pend_coef_ff <= pend_coef_in;
      out_col_ff   <= out_col_in;
      out_coef_ff  <= out_coef_in;
      out_pos_ff   <= out_pos_in;
      out_last_ff  <= out_last_in;
      out_oog_ff   <= out_oog_in;
   end

   assign req_port.ready          = (state_ff == ST_IDLE);
   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.column         = out_col_ff;
   assign rsp_port.coefficient    = out_coef_ff;
   assign rsp_port.entry_position = out_pos_ff;
   assign rsp_port.last           = out_last_ff;
   assign rsp_port.out_of_grid    = out_oog_ff;

   // flagged words are single-word rows with a zero coefficient
   a_oog_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.out_of_grid) |-> (rsp_port.last && rsp_port.coefficient == '0))
      else $error("out-of-grid word not a lone zero entry");

   // the center tap is always in the grid, so a flush always has an entry
   a_flush_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> pend_valid_ff)
      else $error("flush with no held entry");

   // every in-grid word advances the running position by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (out_load && !load_oog) |=> (count_ff == $past(count_ff) + POS_W'(1)))
      else $error("entry count did not advance");

   // a new row never starts with a stale held entry
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_port.ready |-> !pend_valid_ff)
      else $error("held entry left over at row start");

endmodule

### bench/tb_stencil_csr_row_generator.sv
`timescale 1ns / 100ps
// Self-checking bench for stencil_csr_row_generator: random grid points over many
// grid shapes and modes, each CSR row predicted here and compared word by word.
// Depends on scrg_pkg, the channel interfaces in scrg_ifs.sv and the top level.

module tb_stencil_csr_row_generator;

   localparam int EXTENT_CAP   = 1024;
   localparam int QUIET_LIMIT  = 2000;
   localparam int FLUSH_CYCLES = 40;

   // codes with no defined stencil
   localparam logic [scrg_pkg::MODE_W-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [scrg_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [scrg_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct {
      logic [scrg_pkg::COL_W-1:0]         column;
      logic signed [scrg_pkg::COEF_W-1:0] coefficient;
      logic [scrg_pkg::POS_W-1:0]         entry_position;
      logic                               last;
      logic                               out_of_grid;
   } csr_word_type;

   typedef struct {
      int dx;
      int dy;
      int dz;
      int coef;
   } tap_type;

   class csr_row_scoreboard_type;
      logic [scrg_pkg::MODE_W-1:0] mode;
      logic [scrg_pkg::EXT_W-1:0]  width;
      logic [scrg_pkg::EXT_W-1:0]  height;
      logic [scrg_pkg::EXT_W-1:0]  depth;
      logic [scrg_pkg::POS_W-1:0]  nnz_count;
      csr_word_type                expected_words[$];
      tap_type                     taps[$];
      int                          mismatches;

      function new();
         mode       = scrg_pkg::MODE_1D3;
         width      = 11'd10;
         height     = 11'd10;
         depth      = 11'd10;
         nnz_count  = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [scrg_pkg::CSR_IDX_W-1:0] idx,
                              logic [scrg_pkg::EXT_W-1:0] value);
         case (idx)
            scrg_pkg::CSR_MODE:   mode = value[scrg_pkg::MODE_W-1:0];
            scrg_pkg::CSR_WIDTH:  width = value;
            scrg_pkg::CSR_HEIGHT: height = value;
            scrg_pkg::CSR_DEPTH:  depth = value;
            default: ;
         endcase
      endfunction

      function void add_tap(int dx, int dy, int dz, int coef);
         tap_type t;
         t.dx   = dx;
         t.dy   = dy;
         t.dz   = dz;
         t.coef = coef;
         taps.insert(taps.size(), t);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // builds the expected row of one accepted point
      function void note_point(bit restart, int px, int py, int pz);
         int           w, h, d, xx, yy, zz, nzc;
         longint       cols[$];
         int           coefs[$];
         csr_word_type word;
         w = (width > EXTENT_CAP) ? EXTENT_CAP : int'(width);
         h = (height > EXTENT_CAP) ? EXTENT_CAP : int'(height);
         d = (depth > EXTENT_CAP) ? EXTENT_CAP : int'(depth);
         if (restart)
            nnz_count = '0;
         if (mode == scrg_pkg::MODE_1D3) begin
            h  = 1;
            py = 0;
         end
         if (mode <= scrg_pkg::MODE_2D9) begin
            d  = 1;
            pz = 0;
         end
         if (mode > scrg_pkg::MODE_3D27 || px >= w || py >= h || pz >= d) begin
            word.column         = '0;
            word.coefficient    = '0;
            word.entry_position = nnz_count;
            word.last           = 1'b1;
            word.out_of_grid    = 1'b1;
            expected_words.insert(expected_words.size(), word);
            return;
         end
         taps.delete();
         case (mode)
            scrg_pkg::MODE_1D3: begin
               add_tap(-1, 0, 0, -1);
               add_tap(0, 0, 0, 2);
               add_tap(1, 0, 0, -1);
            end
            scrg_pkg::MODE_2D5: begin
               add_tap(0, 0, 0, 4);
               add_tap(-1, 0, 0, -1);
               add_tap(1, 0, 0, -1);
               add_tap(0, -1, 0, -1);
               add_tap(0, 1, 0, -1);
            end
            scrg_pkg::MODE_2D9: begin
               add_tap(0, 0, 0, 8);
               add_tap(-1, 0, 0, -2);
               add_tap(1, 0, 0, -2);
               add_tap(0, -1, 0, -2);
               add_tap(0, 1, 0, -2);
               add_tap(-1, -1, 0, -1);
               add_tap(-1, 1, 0, -1);
               add_tap(1, -1, 0, -1);
               add_tap(1, 1, 0, -1);
            end
            scrg_pkg::MODE_3D7: begin
               add_tap(0, 0, 0, 6);
               add_tap(-1, 0, 0, -1);
               add_tap(1, 0, 0, -1);
               add_tap(0, -1, 0, -1);
               add_tap(0, 1, 0, -1);
               add_tap(0, 0, -1, -1);
               add_tap(0, 0, 1, -1);
            end
            default: begin
               // dz outer, dy middle, dx inner
               for (int c = -1; c <= 1; c++)
                  for (int b = -1; b <= 1; b++)
                     for (int a = -1; a <= 1; a++) begin
                        nzc = int'(a != 0) + int'(b != 0) + int'(c != 0);
                        add_tap(a, b, c, (nzc == 0) ? 26 : ((nzc == 1) ? -4 : -1));
                     end
            end
         endcase
         foreach (taps[i]) begin
            xx = px + taps[i].dx;
            yy = py + taps[i].dy;
            zz = pz + taps[i].dz;
            if (xx < 0 || xx >= w || yy < 0 || yy >= h || zz < 0 || zz >= d)
               continue;
            cols.insert(cols.size(),
                        longint'(xx) + longint'(yy) * w + longint'(zz) * w * h);
            coefs.insert(coefs.size(), taps[i].coef);
         end
         foreach (cols[i]) begin
            word.column         = scrg_pkg::COL_W'(cols[i]);
            word.coefficient    = scrg_pkg::COEF_W'(coefs[i]);
            word.entry_position = nnz_count;
            word.last           = (i == cols.size() - 1);
            word.out_of_grid    = 1'b0;
            expected_words.insert(expected_words.size(), word);
            nnz_count = nnz_count + 1'b1;
         end
      endfunction

      function void check_word(csr_word_type got);
         csr_word_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected word: column %0d, entry_position %0d",
                   got.column, got.entry_position);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         if (got.column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, got.column);
            mismatches++;
         end
         if (got.coefficient !== want.coefficient) begin
            $error("coefficient: expected %0d, got %0d", want.coefficient, got.coefficient);
            mismatches++;
         end
         if (got.entry_position !== want.entry_position) begin
            $error("entry_position: expected %0d, got %0d",
                   want.entry_position, got.entry_position);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
         end
         if (got.out_of_grid !== want.out_of_grid) begin
            $error("out_of_grid: expected %0b, got %0b", want.out_of_grid, got.out_of_grid);
            mismatches++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_write_en;
   logic [scrg_pkg::CSR_IDX_W-1:0] csr_index;
   logic [scrg_pkg::EXT_W-1:0]     csr_wdata;

   scrg_req_if req_if();
   scrg_rsp_if rsp_if();

   stencil_csr_row_generator #(
      .MAX_EXTENT(EXTENT_CAP)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_port    (req_if),
      .rsp_port    (rsp_if)
   );

   csr_row_scoreboard_type sb = new();
   int points_sent  = 0;
   bit steady       = 1'b0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 27);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_word('{rsp_if.column, rsp_if.coefficient, rsp_if.entry_position,
                         rsp_if.last, rsp_if.out_of_grid});
   end

   always @(posedge clock) begin
      if (reset || csr_write_en || (req_if.valid && req_if.ready)
          || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_stencil_csr_row_generator: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // valid stays high from one point to the next unless a gap is rolled
   task automatic send_point(bit restart, int px, int py, int pz);
      if (!steady && $urandom_range(0, 99) < 27) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(0, 99) < 27);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      req_if.point_x <= scrg_pkg::COORD_W'(px);
      req_if.point_y <= scrg_pkg::COORD_W'(py);
      req_if.point_z <= scrg_pkg::COORD_W'(pz);
      do @(posedge clock); while (!req_if.ready);
      sb.note_point(restart, px, py, pz);
      points_sent++;
      steady = (points_sent >= 260 && points_sent < 340);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(logic [scrg_pkg::CSR_IDX_W-1:0] idx, int value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= scrg_pkg::EXT_W'(value);
      @(posedge clock);
      sb.write_reg(idx, scrg_pkg::EXT_W'(value));
   endtask

   task automatic set_grid(logic [scrg_pkg::MODE_W-1:0] mode, int w, int h, int d);
      drain();
      csr_write(scrg_pkg::CSR_MODE, mode);
      csr_write(scrg_pkg::CSR_WIDTH, w);
      csr_write(scrg_pkg::CSR_HEIGHT, h);
      csr_write(scrg_pkg::CSR_DEPTH, d);
      csr_write_en <= 1'b0;
   endtask

   // mostly in-grid with edges favored, some full-range noise
   function automatic int pick_coord(int ext);
      int r, lim;
      r   = $urandom_range(0, 99);
      lim = (ext > EXTENT_CAP) ? EXTENT_CAP : ext;
      if (lim == 0 || r < 15)
         return $urandom_range(0, 1023);
      if (r < 40)
         return $urandom_range(0, 1) ? 0 : lim - 1;
      return $urandom_range(0, lim - 1);
   endfunction

   task automatic random_points(int count);
      int px, py, pz;
      bit rst;
      repeat (count) begin
         rst = ($urandom_range(0, 9) == 0);
         px  = pick_coord(sb.width);
         py  = (sb.mode == scrg_pkg::MODE_1D3) ? $urandom_range(0, 1023)
                                               : pick_coord(sb.height);
         pz  = (sb.mode <= scrg_pkg::MODE_2D9) ? $urandom_range(0, 1023)
                                               : pick_coord(sb.depth);
         send_point(rst, px, py, pz);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= scrg_pkg::CSR_MODE;
      csr_wdata      <= '0;
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'b0;
      req_if.point_x <= '0;
      req_if.point_y <= '0;
      req_if.point_z <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 1D on ten points, y and z ignored
      send_point(1'b1, 0, 0, 0);
      send_point(1'b0, 9, 1023, 1023);
      send_point(1'b0, 10, 0, 0);
      send_point(1'b0, 1023, 512, 7);
      send_point(1'b1, 5, 0, 0);
      random_points(30);

      set_grid(scrg_pkg::MODE_2D5, 1024, 1024, 1);
      send_point(1'b0, 0, 0, 1023);
      send_point(1'b0, 1023, 1023, 0);
      send_point(1'b0, 1023, 0, 512);
      send_point(1'b0, 0, 1023, 0);
      random_points(40);

      set_grid(scrg_pkg::MODE_2D9, 3, 3, 1);
      send_point(1'b0, 1, 1, 0);
      send_point(1'b0, 0, 2, 0);
      send_point(1'b0, 3, 1, 0);
      random_points(50);

      set_grid(scrg_pkg::MODE_3D7, 4, 3, 2);
      send_point(1'b0, 0, 0, 0);
      send_point(1'b0, 3, 2, 1);
      send_point(1'b0, 1, 1, 2);
      random_points(50);

      set_grid(scrg_pkg::MODE_3D27, 3, 3, 3);
      send_point(1'b0, 1, 1, 1);
      send_point(1'b0, 2, 0, 2);
      random_points(60);

      // extents above the cap saturate; largest column index
      set_grid(scrg_pkg::MODE_3D27, 2047, 1024, 1500);
      send_point(1'b0, 1023, 1023, 1023);
      send_point(1'b1, 0, 0, 0);
      random_points(30);

      // zero extents: nothing is in the grid
      set_grid(scrg_pkg::MODE_3D7, 0, 10, 10);
      random_points(10);
      set_grid(scrg_pkg::MODE_2D5, 5, 0, 3);
      random_points(10);

      // single point in 1D, zero height and depth do not matter
      set_grid(scrg_pkg::MODE_1D3, 1, 0, 0);
      send_point(1'b0, 0, 1023, 1023);
      send_point(1'b0, 1, 0, 0);
      random_points(15);

      set_grid(MODE_RSVD5, 4, 4, 4);
      send_point(1'b1, 1, 1, 1);
      random_points(5);
      set_grid(MODE_RSVD6, 4, 4, 4);
      send_point(1'b0, 0, 0, 0);
      random_points(5);
      set_grid(MODE_RSVD7, 4, 4, 4);
      send_point(1'b0, 3, 3, 3);
      random_points(5);

      set_grid(scrg_pkg::MODE_2D5, 1, 1, 7);
      random_points(15);
      set_grid(scrg_pkg::MODE_3D7, 1, 1, 1024);
      random_points(30);
      set_grid(scrg_pkg::MODE_2D9, 7, 5, 2);
      random_points(50);
      set_grid(scrg_pkg::MODE_3D27, 5, 4, 6);
      random_points(60);
      set_grid(scrg_pkg::MODE_1D3, 1024, 3, 3);
      random_points(30);

      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb_stencil_csr_row_generator: clean");
      else
         $display("tb_stencil_csr_row_generator: errors");
      $finish;
   end

endmodule

### sim.f
rtl/scrg_pkg.sv
rtl/scrg_ifs.sv
rtl/stencil_csr_row_generator.sv
bench/tb_stencil_csr_row_generator.sv
